### hdl/bjl_pkg.sv
// Shared types and constants for the Barth-Jespersen gradient limiter.
package bjl_pkg;

    localparam int DATA_W      = 32;
    localparam int ACC_W       = 50;
    localparam int PHI_W       = 17;
    localparam int DIV_STEPS   = 16;
    localparam int STEP_W      = 4;
    localparam int CELL_IDX_W  = 10;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_CELLS_W = 11;
    localparam int CFG_FACES_W = 13;
    localparam int CFG_DB_W    = 16;
    localparam int CFG_CELLS_RESET = 1024;
    localparam int CFG_FACES_RESET = 4096;

    localparam logic [PHI_W-1:0] PHI_ONE = 17'h10000;

    localparam logic [1:0] FUNC_LOAD_CELL = 2'd0;
    localparam logic [1:0] FUNC_LOAD_FACE = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE   = 2'd2;
    localparam logic [1:0] FUNC_READ      = 2'd3;

    localparam logic [1:0] CFG_CELLS = 2'd0;
    localparam logic [1:0] CFG_FACES = 2'd1;
    localparam logic [1:0] CFG_DB    = 2'd2;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic idx_clr;
        logic init_rd;
        logic init_wr;
        logic face_clr;
        logic face_rd;
        logic face_next;
        logic var_next;
        logic mm_rd;
        logic mm_wl;
        logic mm_wr;
        logic lm_rd;
        logic mul;
        logic acc;
        logic chk;
        logic div;
        logic lm_wr;
        logic read_out;
        logic finish;
    } bjl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic idx_last;
        logic face_skip;
        logic face_last;
        logic var_last;
        logic side_right;
        logic dim_last;
        logic trivial;
        logic div_last;
    } bjl_stat_t;

endpackage

### hdl/bjl_ctrl.sv
// Sequencer for load, read, clearing pass and the compute walk.
module bjl_ctrl
    import bjl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] func,
    input  bjl_stat_t  st,
    output logic       busy,
    output bjl_cmd_t   cmd
);

    typedef enum logic [18:0] {
        S_CLEAR   = 19'h00001,
        S_IDLE    = 19'h00002,
        S_READ    = 19'h00004,
        S_INIT_RD = 19'h00008,
        S_INIT_WR = 19'h00010,
        S_MM_FACE = 19'h00020,
        S_MM_FCHK = 19'h00040,
        S_MM_RD   = 19'h00080,
        S_MM_WL   = 19'h00100,
        S_MM_WR   = 19'h00200,
        S_LM_FACE = 19'h00400,
        S_LM_FCHK = 19'h00800,
        S_LM_RD   = 19'h01000,
        S_LM_MUL  = 19'h02000,
        S_LM_ACC  = 19'h04000,
        S_LM_CHK  = 19'h08000,
        S_LM_DIV  = 19'h10000,
        S_LM_WR   = 19'h20000,
        S_DONE    = 19'h40000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (func == FUNC_READ)
                    begin
                        state_next = S_READ;
                    end
                    else if (func == FUNC_COMPUTE)
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_INIT_RD;
                    end
                end
            end
            S_READ:
            begin
                cmd.read_out = 1'b1;
                state_next   = S_IDLE;
            end
            S_INIT_RD:
            begin
                cmd.init_rd = 1'b1;
                state_next  = S_INIT_WR;
            end
            S_INIT_WR:
            begin
                cmd.init_wr = 1'b1;
                if (st.idx_last)
                begin
                    cmd.face_clr = 1'b1;
                    state_next   = S_MM_FACE;
                end
                else
                begin
                    state_next = S_INIT_RD;
                end
            end
            S_MM_FACE:
            begin
                cmd.face_rd = 1'b1;
                state_next  = S_MM_FCHK;
            end
            S_MM_FCHK:
            begin
                if (st.face_skip)
                begin
                    cmd.face_next = 1'b1;
                    if (st.face_last)
                    begin
                        cmd.face_clr = 1'b1;
                        state_next   = S_LM_FACE;
                    end
                    else
                    begin
                        state_next = S_MM_FACE;
                    end
                end
                else
                begin
                    state_next = S_MM_RD;
                end
            end
            S_MM_RD:
            begin
                cmd.mm_rd  = 1'b1;
                state_next = S_MM_WL;
            end
            S_MM_WL:
            begin
                cmd.mm_wl  = 1'b1;
                state_next = S_MM_WR;
            end
            S_MM_WR:
            begin
                cmd.mm_wr    = 1'b1;
                cmd.var_next = 1'b1;
                if (st.var_last)
                begin
                    cmd.face_next = 1'b1;
                    if (st.face_last)
                    begin
                        cmd.face_clr = 1'b1;
                        state_next   = S_LM_FACE;
                    end
                    else
                    begin
                        state_next = S_MM_FACE;
                    end
                end
                else
                begin
                    state_next = S_MM_RD;
                end
            end
            S_LM_FACE:
            begin
                cmd.face_rd = 1'b1;
                state_next  = S_LM_FCHK;
            end
            S_LM_FCHK:
            begin
                if (st.face_skip)
                begin
                    cmd.face_next = 1'b1;
                    state_next    = st.face_last ? S_DONE : S_LM_FACE;
                end
                else
                begin
                    state_next = S_LM_RD;
                end
            end
            S_LM_RD:
            begin
                cmd.lm_rd  = 1'b1;
                state_next = S_LM_MUL;
            end
            S_LM_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_LM_ACC;
            end
            S_LM_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = st.dim_last ? S_LM_CHK : S_LM_MUL;
            end
            S_LM_CHK:
            begin
                cmd.chk    = 1'b1;
                state_next = st.trivial ? S_LM_WR : S_LM_DIV;
            end
            S_LM_DIV:
            begin
                cmd.div = 1'b1;
                if (st.div_last)
                begin
                    state_next = S_LM_WR;
                end
            end
            S_LM_WR:
            begin
                cmd.lm_wr  = 1'b1;
                state_next = S_LM_RD;
                if (st.side_right)
                begin
                    cmd.var_next = 1'b1;
                    if (st.var_last)
                    begin
                        cmd.face_next = 1'b1;
                        state_next    = st.face_last ? S_DONE : S_LM_FACE;
                    end
                end
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/bjl_datapath.sv
// Mesh stores, counters, projection multiplier and limiter divider.
module bjl_datapath
    import bjl_pkg::*;
#(
    parameter int MAX_CELLS = 1024,
    parameter int MAX_FACES = 4096,
    parameter int NUM_VARS  = 4,
    parameter int NUM_DIMS  = 3
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  bjl_cmd_t                      cmd,
    output bjl_stat_t                     st,
    input  logic                          cfg_write,
    input  logic [1:0]                    cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic [1:0]                    func,
    input  logic [11:0]                   item_index,
    input  logic [1:0]                    var_index,
    input  logic signed [DATA_W-1:0]      cell_value,
    input  logic [NUM_DIMS*DATA_W-1:0]    vec_a,
    input  logic [NUM_DIMS*DATA_W-1:0]    vec_b,
    input  logic [CELL_IDX_W-1:0]         left_cell,
    input  logic [CELL_IDX_W-1:0]         right_cell,
    output logic                          done,
    output logic                          result_kind,
    output logic [PHI_W-1:0]              limit_value,
    output logic [CELL_IDX_W-1:0]         cell_echo,
    output logic [1:0]                    var_echo
);

    localparam int CE  = MAX_CELLS * NUM_VARS;
    localparam int AW  = $clog2(CE);
    localparam int FW  = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int VW  = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int DW  = 2;
    localparam int GW  = NUM_DIMS * DATA_W;
    localparam int FVW = 2 * GW;
    localparam int FCW = 2 * CELL_IDX_W;

    logic signed [DATA_W-1:0] cval_mem [CE];
    logic [GW-1:0]            grad_mem [CE];
    logic [FCW-1:0]           fcell_mem [MAX_FACES];
    logic [FVW-1:0]           fvec_mem [MAX_FACES];
    logic signed [DATA_W-1:0] nmin_mem [CE];
    logic signed [DATA_W-1:0] nmax_mem [CE];
    logic [PHI_W-1:0]         lim_mem [CE];

    logic [CFG_CELLS_W-1:0] cells_reg;
    logic [CFG_FACES_W-1:0] faces_reg;
    logic [CFG_DB_W-1:0]    db_reg;

    logic [AW-1:0]     idx_reg;
    logic [FW-1:0]     face_reg;
    logic [VW-1:0]     var_reg;
    logic              side_reg;
    logic [DW-1:0]     dim_reg;
    logic [STEP_W-1:0] step_reg;

    logic signed [DATA_W-1:0] cva_reg, cvb_reg;
    logic signed [DATA_W-1:0] nmna_reg, nmnb_reg, nmxa_reg, nmxb_reg;
    logic [GW-1:0]            grad_reg;
    logic [FCW-1:0]           fcell_reg;
    logic [FVW-1:0]           fvec_reg;
    logic [PHI_W-1:0]         lim_reg;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]         rem_reg, den_reg;
    logic [DIV_STEPS-1:0]     q_reg;
    logic [PHI_W-1:0]         phi_reg;
    logic                     rd_ok_reg;
    logic [CELL_IDX_W-1:0]    rd_cell_reg;
    logic [1:0]               rd_var_reg;

    logic                     done_reg, kind_reg;
    logic [PHI_W-1:0]         limit_reg;
    logic [CELL_IDX_W-1:0]    cecho_reg;
    logic [1:0]               vecho_reg;

    logic [31:0]  nc, nf, n_ent;
    logic [AW-1:0] li, ri, ci, ld_idx, cva_addr, nma_addr, lim_raddr, lim_waddr;
    logic         cell_ok, face_ok, lim_we, nm_we;
    logic [PHI_W-1:0] lim_wdata;
    logic [AW-1:0]    nm_waddr;
    logic signed [DATA_W-1:0] nmin_wdata, nmax_wdata;
    logic signed [DATA_W-1:0] g_op, r_op;
    logic signed [ACC_W-1:0]  db_s, prod_fl;
    logic         pos, neg;
    logic signed [DATA_W:0]   diff;
    logic [ACC_W-1:0] num, den, rem2;
    logic         ge;

    always_comb
    begin
        nc = (cells_reg == '0) ? 32'd1 :
             ((32'(cells_reg) > 32'(MAX_CELLS)) ? 32'(MAX_CELLS) : 32'(cells_reg));
        nf = (faces_reg == '0) ? 32'd1 :
             ((32'(faces_reg) > 32'(MAX_FACES)) ? 32'(MAX_FACES) : 32'(faces_reg));
        n_ent   = nc * 32'(NUM_VARS);
        li      = AW'(32'(fcell_reg[FCW-1:CELL_IDX_W]) * 32'(NUM_VARS) + 32'(var_reg));
        ri      = AW'(32'(fcell_reg[CELL_IDX_W-1:0]) * 32'(NUM_VARS) + 32'(var_reg));
        ci      = side_reg ? ri : li;
        ld_idx  = AW'(32'(item_index) * 32'(NUM_VARS) + 32'(var_index));
        cell_ok = (32'(item_index) < 32'(MAX_CELLS)) && (32'(var_index) < 32'(NUM_VARS));
        face_ok = 32'(item_index) < 32'(MAX_FACES);
        cva_addr  = cmd.init_rd ? idx_reg : (cmd.mm_rd ? li : ci);
        nma_addr  = cmd.mm_rd ? li : ci;
        lim_raddr = cmd.accept ? ld_idx : ci;

        lim_we    = cmd.clr_step || cmd.init_wr || cmd.lm_wr;
        lim_waddr = cmd.lm_wr ? ci : idx_reg;
        lim_wdata = (cmd.lm_wr && (phi_reg < lim_reg)) ? phi_reg :
                    (cmd.lm_wr ? lim_reg : PHI_ONE);

        nm_we      = cmd.init_wr || cmd.mm_wl || cmd.mm_wr;
        nm_waddr   = cmd.mm_wl ? li : (cmd.mm_wr ? ri : idx_reg);
        if (cmd.mm_wl)
        begin
            nmin_wdata = (cvb_reg < nmna_reg) ? cvb_reg : nmna_reg;
            nmax_wdata = (cvb_reg > nmxa_reg) ? cvb_reg : nmxa_reg;
        end
        else if (cmd.mm_wr)
        begin
            nmin_wdata = (cva_reg < nmnb_reg) ? cva_reg : nmnb_reg;
            nmax_wdata = (cva_reg > nmxb_reg) ? cva_reg : nmxb_reg;
        end
        else
        begin
            nmin_wdata = cva_reg;
            nmax_wdata = cva_reg;
        end

        g_op = grad_reg[32'(dim_reg) * DATA_W +: DATA_W];
        r_op = fvec_reg[(32'(side_reg) * NUM_DIMS + 32'(dim_reg)) * DATA_W +: DATA_W];
        prod_fl = ACC_W'(prod_reg >>> 16);

        db_s = $signed({{(ACC_W-CFG_DB_W){1'b0}}, db_reg});
        pos  = acc_reg > db_s;
        neg  = acc_reg < -db_s;
        diff = pos ? ($signed({nmxa_reg[DATA_W-1], nmxa_reg}) - $signed({cva_reg[DATA_W-1], cva_reg}))
                   : ($signed({cva_reg[DATA_W-1], cva_reg}) - $signed({nmna_reg[DATA_W-1], nmna_reg}));
        num  = {{(ACC_W-DATA_W-1){1'b0}}, diff};
        den  = pos ? acc_reg : -acc_reg;
        rem2 = {rem_reg[ACC_W-2:0], 1'b0};
        ge   = rem2 >= den_reg;

        st.clr_last   = 32'(idx_reg) == 32'(CE - 1);
        st.idx_last   = 32'(idx_reg) == n_ent - 32'd1;
        st.face_skip  = (32'(fcell_reg[FCW-1:CELL_IDX_W]) >= nc) ||
                        (32'(fcell_reg[CELL_IDX_W-1:0]) >= nc);
        st.face_last  = 32'(face_reg) == nf - 32'd1;
        st.var_last   = 32'(var_reg) == 32'(NUM_VARS - 1);
        st.side_right = side_reg;
        st.dim_last   = 32'(dim_reg) == 32'(NUM_DIMS - 1);
        st.trivial    = !(pos || neg) || (num >= den);
        st.div_last   = step_reg == STEP_W'(DIV_STEPS - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_reg <= CFG_CELLS_W'(CFG_CELLS_RESET);
            faces_reg <= CFG_FACES_W'(CFG_FACES_RESET);
            db_reg    <= '0;
            idx_reg   <= '0;
            face_reg  <= '0;
            var_reg   <= '0;
            side_reg  <= 1'b0;
            dim_reg   <= '0;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_CELLS)
                begin
                    cells_reg <= cfg_data[CFG_CELLS_W-1:0];
                end
                else if (cfg_index == CFG_FACES)
                begin
                    faces_reg <= cfg_data[CFG_FACES_W-1:0];
                end
                else if (cfg_index == CFG_DB)
                begin
                    db_reg <= cfg_data[CFG_DB_W-1:0];
                end
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                idx_reg <= st.clr_last ? '0 : idx_reg + AW'(1);
            end
            else if (cmd.init_wr)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
            if (cmd.face_clr)
            begin
                face_reg <= '0;
            end
            else if (cmd.face_next)
            begin
                face_reg <= face_reg + FW'(1);
            end
            if (cmd.face_rd)
            begin
                var_reg  <= '0;
                side_reg <= 1'b0;
            end
            else
            begin
                if (cmd.var_next)
                begin
                    var_reg <= st.var_last ? '0 : var_reg + VW'(1);
                end
                if (cmd.lm_wr)
                begin
                    side_reg <= ~side_reg;
                end
            end
            if (cmd.lm_rd)
            begin
                dim_reg <= '0;
            end
            else if (cmd.acc)
            begin
                dim_reg <= dim_reg + DW'(1);
            end
            if (cmd.chk)
            begin
                step_reg <= '0;
            end
            else if (cmd.div)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            done_reg <= cmd.read_out || cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lm_rd)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc)
        begin
            acc_reg <= acc_reg + prod_fl;
        end
        if (cmd.mul)
        begin
            prod_reg <= g_op * r_op;
        end
        if (cmd.chk)
        begin
            rem_reg <= num;
            den_reg <= den;
            q_reg   <= '0;
            if (st.trivial)
            begin
                phi_reg <= PHI_ONE;
            end
        end
        else if (cmd.div)
        begin
            rem_reg <= ge ? rem2 - den_reg : rem2;
            q_reg   <= {q_reg[DIV_STEPS-2:0], ge};
            if (st.div_last)
            begin
                phi_reg <= {1'b0, q_reg[DIV_STEPS-2:0], ge};
            end
        end
        if (cmd.accept && func == FUNC_READ)
        begin
            rd_ok_reg   <= cell_ok;
            rd_cell_reg <= item_index[CELL_IDX_W-1:0];
            rd_var_reg  <= var_index;
        end
        if (cmd.read_out)
        begin
            kind_reg  <= 1'b0;
            limit_reg <= rd_ok_reg ? lim_reg : PHI_ONE;
            cecho_reg <= rd_cell_reg;
            vecho_reg <= rd_var_reg;
        end
        else if (cmd.finish)
        begin
            kind_reg  <= 1'b1;
            limit_reg <= PHI_ONE;
            cecho_reg <= '0;
            vecho_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && func == FUNC_LOAD_CELL && cell_ok)
        begin
            cval_mem[ld_idx] <= cell_value;
            grad_mem[ld_idx] <= vec_a;
        end
        if (cmd.init_rd || cmd.mm_rd || cmd.lm_rd)
        begin
            cva_reg <= cval_mem[cva_addr];
        end
        if (cmd.mm_rd)
        begin
            cvb_reg <= cval_mem[ri];
        end
        if (cmd.lm_rd)
        begin
            grad_reg <= grad_mem[ci];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && func == FUNC_LOAD_FACE && face_ok)
        begin
            fcell_mem[FW'(item_index)] <= {left_cell, right_cell};
            fvec_mem[FW'(item_index)]  <= {vec_b, vec_a};
        end
        if (cmd.face_rd)
        begin
            fcell_reg <= fcell_mem[face_reg];
            fvec_reg  <= fvec_mem[face_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (nm_we)
        begin
            nmin_mem[nm_waddr] <= nmin_wdata;
            nmax_mem[nm_waddr] <= nmax_wdata;
        end
        if (cmd.mm_rd || cmd.lm_rd)
        begin
            nmna_reg <= nmin_mem[nma_addr];
            nmxa_reg <= nmax_mem[nma_addr];
        end
        if (cmd.mm_rd)
        begin
            nmnb_reg <= nmin_mem[ri];
            nmxb_reg <= nmax_mem[ri];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lim_we)
        begin
            lim_mem[lim_waddr] <= lim_wdata;
        end
        if ((cmd.accept && func == FUNC_READ) || cmd.lm_rd)
        begin
            lim_reg <= lim_mem[lim_raddr];
        end
    end

    assign done        = done_reg;
    assign result_kind = kind_reg;
    assign limit_value = limit_reg;
    assign cell_echo   = cecho_reg;
    assign var_echo    = vecho_reg;

endmodule

### hdl/barth_jespersen_gradient_limiter.sv
// Barth-Jespersen gradient limiter over an unstructured mesh, top level.
// Loads are taken in idle and may follow back to back; a read passes through the read state and its beat is registered.
// Compute walks the stores with busy high: an init pass over C cells and V variables,
// a min/max pass and a limiter pass over F faces (N dims), using the one shared multiplier
// and the radix-2 divider (16 steps); the done beat follows the walk.
// After reset the limiter store is swept to 1.0 over all MAX_CELLS*NUM_VARS entries with busy high.
// Result beats last one cycle each; the receiver cannot stall.
module barth_jespersen_gradient_limiter
    import bjl_pkg::*;
#(
    parameter int MAX_CELLS = 1024,
    parameter int MAX_FACES = 4096,
    parameter int NUM_VARS  = 4,
    parameter int NUM_DIMS  = 3
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     cfg_write,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic [1:0]               func,
    input  logic [11:0]              item_index,
    input  logic [1:0]               var_index,
    input  logic signed [31:0]       cell_value,
    input  logic signed [31:0]       vec_a_x,
    input  logic signed [31:0]       vec_a_y,
    input  logic signed [31:0]       vec_a_z,
    input  logic signed [31:0]       vec_b_x,
    input  logic signed [31:0]       vec_b_y,
    input  logic signed [31:0]       vec_b_z,
    input  logic [9:0]               left_cell,
    input  logic [9:0]               right_cell,
    output logic                     done,
    output logic                     result_kind,
    output logic [16:0]              limit_value,
    output logic [9:0]               cell_echo,
    output logic [1:0]               var_echo
);

    bjl_cmd_t  cmd;
    bjl_stat_t st;
    logic [NUM_DIMS*DATA_W-1:0] vec_a, vec_b;

    generate
        if (NUM_DIMS == 3)
        begin : g_3d
            assign vec_a = {vec_a_z, vec_a_y, vec_a_x};
            assign vec_b = {vec_b_z, vec_b_y, vec_b_x};
        end
        else
        begin : g_2d
            assign vec_a = {vec_a_y, vec_a_x};
            assign vec_b = {vec_b_y, vec_b_x};
        end
    endgenerate

    bjl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .st    (st),
        .busy  (busy),
        .cmd   (cmd)
    );

    bjl_datapath #(
        .MAX_CELLS (MAX_CELLS),
        .MAX_FACES (MAX_FACES),
        .NUM_VARS  (NUM_VARS),
        .NUM_DIMS  (NUM_DIMS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .func        (func),
        .item_index  (item_index),
        .var_index   (var_index),
        .cell_value  (cell_value),
        .vec_a       (vec_a),
        .vec_b       (vec_b),
        .left_cell   (left_cell),
        .right_cell  (right_cell),
        .done        (done),
        .result_kind (result_kind),
        .limit_value (limit_value),
        .cell_echo   (cell_echo),
        .var_echo    (var_echo)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == FUNC_COMPUTE) |=> busy)
        else $error("compute accepted without going busy");

    a_finish_one: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result_kind) |-> (limit_value == PHI_ONE && cell_echo == '0))
        else $error("compute beat carries wrong payload");

    a_phi_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (limit_value <= PHI_ONE))
        else $error("limiter above one");

endmodule

### test/tb_barth_jespersen_gradient_limiter.sv
// Self-checking testbench for the Barth-Jespersen gradient limiter: queued commands, scoreboard.
`timescale 1ns / 1ps

module tb_barth_jespersen_gradient_limiter;
    import bjl_pkg::*;

    localparam int NCELL = 1024;
    localparam int NFACE = 4096;
    localparam int NVAR  = 4;
    localparam int NDIM  = 3;
    localparam int LIMIT = 3000000;
    localparam logic [1:0] CFG_NONE = 2'd3;

    typedef struct {
        logic [1:0]         func;
        logic [11:0]        idx;
        logic [1:0]         vsel;
        logic signed [31:0] val;
        logic signed [31:0] ax, ay, az, bx, by, bz;
        logic [9:0]         lc, rc;
    } cmd_t;

    typedef struct {
        logic        kind;
        logic [16:0] phi;
        logic [9:0]  cix;
        logic [1:0]  vsel;
    } beat_t;

    logic clk, rst_n, start, busy, cfg_write, done;
    logic [1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic [1:0] func, var_index;
    logic [11:0] item_index;
    logic signed [31:0] cell_value, vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z;
    logic [9:0] left_cell, right_cell;
    logic result_kind;
    logic [16:0] limit_value;
    logic [9:0] cell_echo;
    logic [1:0] var_echo;

    barth_jespersen_gradient_limiter u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .func(func), .item_index(item_index), .var_index(var_index),
        .cell_value(cell_value), .vec_a_x(vec_a_x), .vec_a_y(vec_a_y), .vec_a_z(vec_a_z),
        .vec_b_x(vec_b_x), .vec_b_y(vec_b_y), .vec_b_z(vec_b_z),
        .left_cell(left_cell), .right_cell(right_cell), .done(done),
        .result_kind(result_kind), .limit_value(limit_value),
        .cell_echo(cell_echo), .var_echo(var_echo)
    );

    // mesh mirror
    int unsigned m_cells, m_faces, m_db;
    longint m_val  [NCELL*NVAR];
    longint m_grad [NCELL*NVAR*NDIM];
    int unsigned m_fl [NFACE];
    int unsigned m_fr [NFACE];
    longint m_fvec [NFACE*2*NDIM];
    longint m_lo   [NCELL*NVAR];
    longint m_hi   [NCELL*NVAR];
    logic [16:0] m_phi [NCELL*NVAR];

    cmd_t  pending[$];
    beat_t awaited[$];
    int errors, accepted, beats, computes, cycles;
    bit calm;

    function automatic longint face_delta(int unsigned c, int unsigned v, int unsigned f,
                                          int unsigned s);
        longint acc;
        acc = 0;
        for (int d = 0; d < NDIM; d++)
            acc += (m_grad[(c*NVAR+v)*NDIM+d] * m_fvec[(f*2+s)*NDIM+d]) >>> 16;
        return acc;
    endfunction

    function automatic logic [16:0] side_limit(longint delta, longint u, longint lo,
                                               longint hi);
        longint unsigned num, den, q;
        if (delta > longint'(m_db)) begin
            num = hi - u;
            den = delta;
        end else if (delta < -longint'(m_db)) begin
            num = u - lo;
            den = -delta;
        end else
            return PHI_ONE;
        q = (num << 16) / den;
        return (q > 65536) ? PHI_ONE : q[16:0];
    endfunction

    function automatic void limit_pass();
        int unsigned nc, nf, l, r, li, ri;
        logic [16:0] pl, pr;
        nc = (m_cells < 1) ? 1 : (m_cells > NCELL ? NCELL : m_cells);
        nf = (m_faces < 1) ? 1 : (m_faces > NFACE ? NFACE : m_faces);
        for (int i = 0; i < nc*NVAR; i++) begin
            m_lo[i] = m_val[i];
            m_hi[i] = m_val[i];
            m_phi[i] = PHI_ONE;
        end
        for (int f = 0; f < nf; f++) begin
            l = m_fl[f];
            r = m_fr[f];
            if (l >= nc || r >= nc) continue;
            for (int v = 0; v < NVAR; v++) begin
                li = l*NVAR+v;
                ri = r*NVAR+v;
                if (m_val[ri] < m_lo[li]) m_lo[li] = m_val[ri];
                if (m_val[ri] > m_hi[li]) m_hi[li] = m_val[ri];
                if (m_val[li] < m_lo[ri]) m_lo[ri] = m_val[li];
                if (m_val[li] > m_hi[ri]) m_hi[ri] = m_val[li];
            end
        end
        for (int f = 0; f < nf; f++) begin
            l = m_fl[f];
            r = m_fr[f];
            if (l >= nc || r >= nc) continue;
            for (int v = 0; v < NVAR; v++) begin
                li = l*NVAR+v;
                ri = r*NVAR+v;
                pl = side_limit(face_delta(l, v, f, 0), m_val[li], m_lo[li], m_hi[li]);
                pr = side_limit(face_delta(r, v, f, 1), m_val[ri], m_lo[ri], m_hi[ri]);
                if (pl < m_phi[li]) m_phi[li] = pl;
                if (pr < m_phi[ri]) m_phi[ri] = pr;
            end
        end
    endfunction

    function automatic void apply_cmd(cmd_t c);
        beat_t b;
        int unsigned k;
        case (c.func)
            FUNC_LOAD_CELL: if (c.idx < NCELL) begin
                k = c.idx*NVAR + c.vsel;
                m_val[k] = c.val;
                m_grad[k*NDIM]   = c.ax;
                m_grad[k*NDIM+1] = c.ay;
                m_grad[k*NDIM+2] = c.az;
            end
            FUNC_LOAD_FACE: if (c.idx < NFACE) begin
                m_fl[c.idx] = c.lc;
                m_fr[c.idx] = c.rc;
                m_fvec[c.idx*6]   = c.ax;
                m_fvec[c.idx*6+1] = c.ay;
                m_fvec[c.idx*6+2] = c.az;
                m_fvec[c.idx*6+3] = c.bx;
                m_fvec[c.idx*6+4] = c.by;
                m_fvec[c.idx*6+5] = c.bz;
            end
            FUNC_COMPUTE: begin
                limit_pass();
                b = '{1'b1, PHI_ONE, 10'd0, 2'd0};
                awaited.push_back(b);
                computes++;
            end
            default: begin
                b.kind = 1'b0;
                b.phi  = (c.idx < NCELL) ? m_phi[c.idx*NVAR + c.vsel] : PHI_ONE;
                b.cix  = c.idx[9:0];
                b.vsel = c.vsel;
                awaited.push_back(b);
            end
        endcase
    endfunction

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // driver
    always @(posedge clk) begin
        if (!rst_n)
            start <= 1'b0;
        else begin
            if (start && !busy) begin
                apply_cmd(pending.pop_front());
                accepted++;
            end
            if (start && busy)
                start <= 1'b1;
            else if (pending.size() > 0 && (calm || $urandom_range(0, 99) >= 24)) begin
                start      <= 1'b1;
                func       <= pending[0].func;
                item_index <= pending[0].idx;
                var_index  <= pending[0].vsel;
                cell_value <= pending[0].val;
                vec_a_x    <= pending[0].ax;
                vec_a_y    <= pending[0].ay;
                vec_a_z    <= pending[0].az;
                vec_b_x    <= pending[0].bx;
                vec_b_y    <= pending[0].by;
                vec_b_z    <= pending[0].bz;
                left_cell  <= pending[0].lc;
                right_cell <= pending[0].rc;
            end else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk) begin
        beat_t w;
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
        if (rst_n && done) begin
            beats++;
            if (awaited.size() == 0) begin
                $error("unexpected beat kind=%0d value=%0d", result_kind, limit_value);
                errors++;
            end else begin
                w = awaited.pop_front();
                if (result_kind !== w.kind) begin
                    $error("result_kind exp %0d got %0d", w.kind, result_kind);
                    errors++;
                end
                if (limit_value !== w.phi) begin
                    $error("limit_value exp %0d got %0d", w.phi, limit_value);
                    errors++;
                end
                if (cell_echo !== w.cix) begin
                    $error("cell_echo exp %0d got %0d", w.cix, cell_echo);
                    errors++;
                end
                if (var_echo !== w.vsel) begin
                    $error("var_echo exp %0d got %0d", w.vsel, var_echo);
                    errors++;
                end
            end
        end
    end

    function automatic logic signed [31:0] rnd_word(int unsigned span);
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $signed($urandom_range(0, 2*span)) - $signed(span);
    endfunction

    function automatic cmd_t blank(logic [1:0] f, int unsigned idx, int unsigned v);
        cmd_t c;
        c = '{f, idx[11:0], v[1:0], 0, 0, 0, 0, 0, 0, 0, 10'd0, 10'd0};
        return c;
    endfunction

    task automatic put_cell(int unsigned idx, int unsigned v);
        cmd_t c;
        c = blank(FUNC_LOAD_CELL, idx, v);
        c.val = rnd_word(1 << 20);
        c.ax = rnd_word(1 << 18);
        c.ay = rnd_word(1 << 18);
        c.az = rnd_word(1 << 18);
        pending.push_back(c);
    endtask

    task automatic put_face(int unsigned idx, int unsigned nc);
        cmd_t c;
        c = blank(FUNC_LOAD_FACE, idx, 0);
        c.lc = ($urandom_range(0, 11) == 0) ? 10'($urandom) : 10'($urandom_range(0, nc-1));
        c.rc = ($urandom_range(0, 11) == 0) ? 10'($urandom) : 10'($urandom_range(0, nc-1));
        c.ax = rnd_word(1 << 17);
        c.ay = rnd_word(1 << 17);
        c.az = rnd_word(1 << 17);
        c.bx = rnd_word(1 << 17);
        c.by = rnd_word(1 << 17);
        c.bz = rnd_word(1 << 17);
        pending.push_back(c);
    endtask

    task automatic settle();
        while (pending.size() != 0 || awaited.size() != 0 || start || busy)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_reg(logic [1:0] idx, int unsigned value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[15:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_CELLS) m_cells = value & 16'h7FF;
        else if (idx == CFG_FACES) m_faces = value & 16'h1FFF;
        else if (idx == CFG_DB) m_db = value & 16'hFFFF;
    endtask

    // full reload, noise, compute, then reads
    task automatic mesh_phase(int unsigned nc, int unsigned nf, int unsigned db,
                              int unsigned noise);
        int unsigned ncu, nfu, pick;
        settle();
        set_reg(CFG_CELLS, nc);
        set_reg(CFG_FACES, nf);
        set_reg(CFG_DB, db);
        ncu = (nc < 1) ? 1 : nc;
        nfu = (nf < 1) ? 1 : nf;
        for (int i = 0; i < ncu; i++)
            for (int v = 0; v < NVAR; v++)
                put_cell(i, v);
        for (int f = 0; f < nfu; f++)
            put_face(f, ncu);
        for (int n = 0; n < noise; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) put_cell($urandom_range(0, ncu-1), $urandom_range(0, 3));
            else if (pick < 5) put_face($urandom_range(0, nfu-1), ncu);
            else if (pick == 5) put_cell($urandom_range(1024, 4095), $urandom_range(0, 3));
            else if (pick == 6) put_face($urandom_range(0, 4095), ncu);
            else pending.push_back(blank(FUNC_READ, $urandom_range(0, 4095),
                                         $urandom_range(0, 3)));
        end
        pending.push_back(blank(FUNC_COMPUTE, $urandom, $urandom));
        for (int n = 0; n < ncu*NVAR/2 + 4; n++)
            pending.push_back(blank(FUNC_READ, ($urandom_range(0, 7) == 0)
                                    ? $urandom_range(0, 4095) : $urandom_range(0, ncu + 1),
                                    $urandom_range(0, 3)));
    endtask

    initial begin
        cmd_t c;
        rst_n = 1'b0;
        start = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_CELLS;
        cfg_data = '0;
        func = FUNC_LOAD_CELL;
        item_index = '0;
        var_index = '0;
        cell_value = '0;
        vec_a_x = '0; vec_a_y = '0; vec_a_z = '0;
        vec_b_x = '0; vec_b_y = '0; vec_b_z = '0;
        left_cell = '0;
        right_cell = '0;
        errors = 0; accepted = 0; beats = 0; computes = 0; cycles = 0;
        calm = 1'b0;
        m_cells = 1024; m_faces = 4096; m_db = 0;
        for (int i = 0; i < NCELL*NVAR; i++) begin
            m_val[i] = 0; m_lo[i] = 0; m_hi[i] = 0; m_phi[i] = PHI_ONE;
        end
        for (int i = 0; i < NCELL*NVAR*NDIM; i++) m_grad[i] = 0;
        for (int i = 0; i < NFACE; i++) begin
            m_fl[i] = 0; m_fr[i] = 0;
        end
        for (int i = 0; i < NFACE*2*NDIM; i++) m_fvec[i] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: defaults, extreme indices and values, out-of-range reads
        c = blank(FUNC_LOAD_CELL, 1023, 3);
        c.val = 32'sh7FFFFFFF; c.ax = 32'sh80000000; c.ay = 32'sh7FFFFFFF; c.az = -1;
        pending.push_back(c);
        c = blank(FUNC_LOAD_CELL, 4095, 3);
        c.val = 32'sh80000000; c.ax = -1; c.ay = -1; c.az = -1;
        pending.push_back(c);
        c = blank(FUNC_LOAD_FACE, 4095, 0);
        c.lc = 10'h3FF; c.rc = 10'h3FF;
        c.ax = 32'sh7FFFFFFF; c.by = 32'sh80000000; c.bz = -1;
        pending.push_back(c);
        pending.push_back(blank(FUNC_READ, 1023, 3));
        pending.push_back(blank(FUNC_READ, 4095, 3));
        pending.push_back(blank(FUNC_READ, 1024, 0));
        pending.push_back(blank(FUNC_READ, 0, 0));
        settle();
        set_reg(CFG_NONE, 16'hFFFF);
        set_reg(CFG_CELLS, 1024);
        set_reg(CFG_FACES, 4096);
        set_reg(CFG_DB, 65535);
        pending.push_back(blank(FUNC_READ, 2047, 2));

        // mesh phases: smallest mesh, zero register values, full dead band
        mesh_phase(1, 1, 0, 4);
        mesh_phase(0, 0, 0, 4);
        mesh_phase(2, 3, 65535, 6);
        mesh_phase(3, 4, 0, 8);
        for (int p = 0; p < 12; p++) begin
            calm = (p >= 5 && p < 8);
            mesh_phase($urandom_range(1, 8), $urandom_range(1, 12),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 2000),
                       $urandom_range(10, 40));
        end
        calm = 1'b0;
        settle();
        repeat (100) @(posedge clk);
        $display("%0d commands accepted, %0d beats checked, %0d limiter passes",
                 accepted, beats, computes);
        if (errors == 0 && awaited.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### filelist.f
hdl/bjl_pkg.sv
hdl/bjl_ctrl.sv
hdl/bjl_datapath.sv
hdl/barth_jespersen_gradient_limiter.sv
test/tb_barth_jespersen_gradient_limiter.sv
